[rtl/msrg_pkg.sv]
// Shared types and constants of the multi-stop RGB gradient block.
package msrg_pkg;

  localparam int CHAN_W     = 8;
  localparam int PIX_W      = 8;
  localparam int NPIX_W     = 9;
  localparam int NSTOP_W    = 5;
  localparam int BRI_W      = 8;
  localparam int STOP_IDX_W = 4;
  localparam int PROD_W     = CHAN_W + NPIX_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam int FIFO_DEPTH = 4;
  localparam int NUM_CHAN   = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_PIXELS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_STOPS  = 2'd2;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_RENDER = 1'b1;

  localparam logic [BRI_W-1:0]   BRIGHTNESS_RST = 8'd100;
  localparam logic [NPIX_W-1:0]  NUM_PIXELS_RST = 9'd1;
  localparam logic [NSTOP_W-1:0] NUM_STOPS_RST  = 5'd2;

  typedef struct packed {
    logic [CHAN_W-1:0] g;
    logic [CHAN_W-1:0] r;
    logic [CHAN_W-1:0] b;
  } grb_t;

  // Segment geometry derived from the configuration registers.
  typedef struct packed {
    logic              busy;
    logic [NPIX_W-1:0] npix;
    logic [NPIX_W-1:0] seg_size;
    logic [NPIX_W-1:0] seg_steps;
    logic [NPIX_W-1:0] last_start;
    logic [NPIX_W-1:0] last_steps;
  } seg_info_t;

  // One front pipeline stage: a load or a render whose segment is being found.
  typedef struct packed {
    logic                  is_load;
    logic [STOP_IDX_W-1:0] stop_index;
    grb_t                  grb;
    logic [PIX_W-1:0]      pix;
    logic [PIX_W-1:0]      rem;
    logic [PIX_W-1:0]      q;
  } fstage_t;

  // Classified render handed from the front to the back.
  typedef struct packed {
    logic [PIX_W-1:0]  pix;
    logic [NPIX_W-1:0] pos;
    logic [NPIX_W-1:0] steps;
    grb_t              stop_a;
    grb_t              stop_b;
  } job_t;

  typedef struct packed {
    logic [CHAN_W-1:0] c1;
    logic              neg;
    logic [PROD_W-1:0] rem;
    logic [CHAN_W-1:0] q;
  } chan_work_t;

  typedef struct packed {
    logic [PIX_W-1:0]            pix;
    logic [NPIX_W-1:0]           steps;
    chan_work_t [NUM_CHAN-1:0]   ch;
  } bstage_t;

endpackage

[rtl/msrg_if.sv]
// Channel interfaces of the gradient block: configuration, input and result.
interface msrg_cfg_if import msrg_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

interface msrg_in_if import msrg_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  op;
  logic [STOP_IDX_W-1:0] stop_index;
  logic [CHAN_W-1:0]     stop_g;
  logic [CHAN_W-1:0]     stop_r;
  logic [CHAN_W-1:0]     stop_b;
  logic [PIX_W-1:0]      pixel_index;

  modport source (output valid, output op, output stop_index, output stop_g, output stop_r,
                  output stop_b, output pixel_index, input ready);
  modport sink   (input valid, input op, input stop_index, input stop_g, input stop_r,
                  input stop_b, input pixel_index, output ready);
endinterface

interface msrg_out_if import msrg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PIX_W-1:0]  pixel_out_index;
  logic [CHAN_W-1:0] out_g;
  logic [CHAN_W-1:0] out_r;
  logic [CHAN_W-1:0] out_b;

  modport source (output valid, output pixel_out_index, output out_g, output out_r,
                  output out_b, input ready);
  modport sink   (input valid, input pixel_out_index, input out_g, input out_r,
                  input out_b, output ready);
endinterface

[rtl/msrg_cfg.sv]
// Configuration registers and the sequencer that derives the segment geometry.
module msrg_cfg import msrg_pkg::*; #(
  parameter int PIXELS_MAX = 256,
  parameter int STOPS_MAX  = 16,
  localparam int AW        = $clog2(STOPS_MAX)
) (
  input  logic             clk,
  input  logic             rst_n,
  msrg_cfg_if.sink         cfg_ch,
  output logic [BRI_W-1:0] brightness,
  output seg_info_t        seg,
  output logic [AW-1:0]    last_k
);

  localparam logic [2:0] DS_IDLE  = 3'd0;
  localparam logic [2:0] DS_START = 3'd1;
  localparam logic [2:0] DS_DIV   = 3'd2;
  localparam logic [2:0] DS_MUL   = 3'd3;
  localparam logic [2:0] DS_SUB   = 3'd4;
  localparam int CW = $clog2(NPIX_W);

  logic [BRI_W-1:0]   brightness_r;
  logic [NPIX_W-1:0]  num_pixels_r;
  logic [NSTOP_W-1:0] num_stops_r;
  logic [2:0]         state_r, state_nxt;
  logic [NPIX_W-1:0]  dq_r, dq_nxt;
  logic [AW-1:0]      rem_r, rem_nxt;
  logic [CW-1:0]      cnt_r;
  logic [NPIX_W-1:0]  last_start_r;
  logic [NPIX_W-1:0]  last_steps_r;
  logic [NPIX_W-1:0]  npix;
  logic [AW-1:0]      segs;
  logic [AW:0]        rem_sh;
  logic               ge;
  logic               cfg_acc;

  assign cfg_ch.ready = 1'b1;
  assign cfg_acc      = cfg_ch.valid;

  always_comb begin
    if (32'(num_pixels_r) > PIXELS_MAX) npix = NPIX_W'(PIXELS_MAX);
    else                                npix = num_pixels_r;
    if (num_stops_r < 5'd2)                  segs = AW'(1);
    else if (32'(num_stops_r) > STOPS_MAX)   segs = AW'(STOPS_MAX - 1);
    else                                     segs = AW'(num_stops_r - 5'd1);
  end

  // Restoring division npix / segs, one quotient bit per cycle.
  always_comb begin
    rem_sh = {rem_r, dq_r[NPIX_W-1]};
    ge     = rem_sh >= {1'b0, segs};
    if (ge) rem_nxt = AW'(rem_sh - {1'b0, segs});
    else    rem_nxt = rem_sh[AW-1:0];
    dq_nxt = {dq_r[NPIX_W-2:0], ge};
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      DS_IDLE:  state_nxt = DS_IDLE;
      DS_START: state_nxt = DS_DIV;
      DS_DIV:   if (cnt_r == '0) state_nxt = DS_MUL;
      DS_MUL:   state_nxt = DS_SUB;
      DS_SUB:   state_nxt = DS_IDLE;
      default:  state_nxt = DS_START;
    endcase
    if (cfg_acc) state_nxt = DS_START;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      brightness_r <= BRIGHTNESS_RST;
      num_pixels_r <= NUM_PIXELS_RST;
      num_stops_r  <= NUM_STOPS_RST;
      state_r      <= DS_START;
    end else begin
      state_r <= state_nxt;
      if (cfg_acc) begin
        case (cfg_ch.index)
          CFG_BRIGHTNESS: brightness_r <= cfg_ch.data[BRI_W-1:0];
          CFG_NUM_PIXELS: num_pixels_r <= cfg_ch.data[NPIX_W-1:0];
          CFG_NUM_STOPS:  num_stops_r  <= cfg_ch.data[NSTOP_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      DS_START: begin
        dq_r  <= npix;
        rem_r <= '0;
        cnt_r <= CW'(NPIX_W - 1);
      end
      DS_DIV: begin
        dq_r  <= dq_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r - CW'(1);
      end
      DS_MUL: last_start_r <= NPIX_W'(dq_r * (segs - AW'(1)));
      DS_SUB: last_steps_r <= npix - last_start_r - NPIX_W'(1);
      default: ;
    endcase
  end

  assign brightness     = brightness_r;
  assign last_k         = segs - AW'(1);
  assign seg.busy       = (state_r != DS_IDLE);
  assign seg.npix       = npix;
  assign seg.seg_size   = dq_r;
  assign seg.seg_steps  = dq_r - NPIX_W'(1);
  assign seg.last_start = last_start_r;
  assign seg.last_steps = last_steps_r;

endmodule

[rtl/msrg_front.sv]
// Front end: accepts items, finds each pixel's segment and owns the stop table.
module msrg_front import msrg_pkg::*; #(
  parameter int STOPS_MAX = 16,
  localparam int AW       = $clog2(STOPS_MAX)
) (
  input  logic          clk,
  input  logic          rst_n,
  msrg_in_if.sink       in_ch,
  input  seg_info_t     seg,
  input  logic [AW-1:0] last_k,
  output logic          push_valid,
  output job_t          push_data,
  input  logic          push_ready
);

  localparam int DW = PIX_W + NPIX_W;

  fstage_t           st_r   [PIX_W+1];
  fstage_t           st_nxt [PIX_W+1];
  logic [PIX_W:0]    vld_r;
  logic              front_adv;
  logic              in_acc;
  logic              keep;
  grb_t              tbl [STOPS_MAX];
  grb_t              a_r, b_r;
  logic              t_vld_r;
  logic [PIX_W-1:0]  t_pix_r;
  logic [NPIX_W-1:0] t_pos_r, t_steps_r;
  fstage_t           tail;
  logic              in_last;
  logic [AW-1:0]     k;
  logic [NPIX_W-1:0] pos, steps;
  logic              wr_ok;

  assign front_adv   = !t_vld_r || push_ready;
  assign in_ch.ready = front_adv && !seg.busy;
  assign in_acc      = in_ch.valid && in_ch.ready;
  // Renders outside the strip are taken and dropped here.
  assign keep = (in_ch.op == OP_LOAD) || (NPIX_W'(in_ch.pixel_index) < seg.npix);

  // Stage j settles quotient bit PIX_W-j of pix / seg_size.
  always_comb begin
    st_nxt[0].is_load    = (in_ch.op == OP_LOAD);
    st_nxt[0].stop_index = in_ch.stop_index;
    st_nxt[0].grb        = '{g: in_ch.stop_g, r: in_ch.stop_r, b: in_ch.stop_b};
    st_nxt[0].pix        = in_ch.pixel_index;
    st_nxt[0].rem        = in_ch.pixel_index;
    st_nxt[0].q          = '0;
    for (int j = 1; j <= PIX_W; j++) begin
      st_nxt[j] = st_r[j-1];
      if (DW'(st_r[j-1].rem) >= (DW'(seg.seg_size) << (PIX_W - j))) begin
        st_nxt[j].rem = PIX_W'(DW'(st_r[j-1].rem) - (DW'(seg.seg_size) << (PIX_W - j)));
        st_nxt[j].q[PIX_W-j] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      t_vld_r <= 1'b0;
    end else if (front_adv) begin
      vld_r   <= {vld_r[PIX_W-1:0], in_acc && keep};
      t_vld_r <= vld_r[PIX_W] && !st_r[PIX_W].is_load;
    end
  end

  always_ff @(posedge clk) begin
    if (front_adv) begin
      for (int j = 0; j <= PIX_W; j++) st_r[j] <= st_nxt[j];
    end
  end

  // Classification: pixels at or past the last segment's start belong to it.
  always_comb begin
    tail    = st_r[PIX_W];
    in_last = NPIX_W'(tail.pix) >= seg.last_start;
    if (in_last) begin
      k     = last_k;
      pos   = NPIX_W'(tail.pix) - seg.last_start;
      steps = seg.last_steps;
    end else begin
      k     = tail.q[AW-1:0];
      pos   = NPIX_W'(tail.rem);
      steps = seg.seg_steps;
    end
    wr_ok = 32'(tail.stop_index) < STOPS_MAX;
  end

  // Loads and renders reach the table in arrival order.
  always_ff @(posedge clk) begin
    if (front_adv) begin
      if (vld_r[PIX_W] && tail.is_load && wr_ok) tbl[AW'(tail.stop_index)] <= tail.grb;
      a_r       <= tbl[k];
      b_r       <= tbl[k + AW'(1)];
      t_pix_r   <= tail.pix;
      t_pos_r   <= pos;
      t_steps_r <= steps;
    end
  end

  assign push_valid       = t_vld_r;
  assign push_data.pix    = t_pix_r;
  assign push_data.pos    = t_pos_r;
  assign push_data.steps  = t_steps_r;
  assign push_data.stop_a = a_r;
  assign push_data.stop_b = b_r;

endmodule

[rtl/msrg_fifo.sv]
// Short queue of classified renders between the front and the back.
module msrg_fifo import msrg_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  input  job_t push_data,
  output logic push_ready,
  output logic pop_valid,
  output job_t pop_data,
  input  logic pop_ready
);

  localparam int PW = $clog2(FIFO_DEPTH);

  job_t          mem_r [FIFO_DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [PW:0]   count_r;
  logic          push, pop;

  assign push_ready = (count_r != (PW+1)'(FIFO_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + PW'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + PW'(1);
      if (push && !pop)      count_r <= count_r + (PW+1)'(1);
      else if (pop && !push) count_r <= count_r - (PW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

[rtl/msrg_back.sv]
// Back end: interpolates the three channels and applies the brightness scale.
module msrg_back import msrg_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             pop_valid,
  input  job_t             pop_data,
  output logic             pop_ready,
  input  logic [BRI_W-1:0] brightness,
  msrg_out_if.source       out_ch
);

  localparam int SW = 2 * CHAN_W;

  bstage_t           bs_r   [CHAN_W+1];
  bstage_t           bs_nxt [CHAN_W+1];
  logic [CHAN_W:0]   bvld_r;
  logic              m_vld_r;
  logic [PIX_W-1:0]  m_pix_r;
  logic [SW-1:0]     m_prod_r [NUM_CHAN];
  logic              out_valid_r;
  logic [PIX_W-1:0]  o_pix_r;
  logic [CHAN_W-1:0] o_chan_r [NUM_CHAN];
  logic              back_adv;
  logic [CHAN_W-1:0] ca [NUM_CHAN];
  logic [CHAN_W-1:0] cb [NUM_CHAN];
  logic [CHAN_W-1:0] mag [NUM_CHAN];
  logic [CHAN_W-1:0] v [NUM_CHAN];
  bstage_t           last;

  // x / 255 for any product of two 8-bit values.
  function automatic logic [CHAN_W-1:0] div255(input logic [SW-1:0] x);
    logic [SW:0] s;
    s = (SW+1)'(x) + (SW+1)'(1) + (SW+1)'(x[SW-1:CHAN_W]);
    return s[SW-1:CHAN_W];
  endfunction

  assign back_adv  = !out_valid_r || out_ch.ready;
  assign pop_ready = back_adv;

  always_comb begin
    ca[0] = pop_data.stop_a.g;  cb[0] = pop_data.stop_b.g;
    ca[1] = pop_data.stop_a.r;  cb[1] = pop_data.stop_b.r;
    ca[2] = pop_data.stop_a.b;  cb[2] = pop_data.stop_b.b;
    bs_nxt[0].pix   = pop_data.pix;
    bs_nxt[0].steps = pop_data.steps;
    for (int c = 0; c < NUM_CHAN; c++) begin
      bs_nxt[0].ch[c].c1  = ca[c];
      bs_nxt[0].ch[c].neg = cb[c] < ca[c];
      mag[c] = (cb[c] < ca[c]) ? ca[c] - cb[c] : cb[c] - ca[c];
      bs_nxt[0].ch[c].rem = PROD_W'(mag[c]) * PROD_W'(pop_data.pos);
      bs_nxt[0].ch[c].q   = '0;
    end
    // Stage j settles quotient bit CHAN_W-j of |diff| * pos / steps.
    for (int j = 1; j <= CHAN_W; j++) begin
      bs_nxt[j] = bs_r[j-1];
      for (int c = 0; c < NUM_CHAN; c++) begin
        if (bs_r[j-1].ch[c].rem >= (PROD_W'(bs_r[j-1].steps) << (CHAN_W - j))) begin
          bs_nxt[j].ch[c].rem = bs_r[j-1].ch[c].rem -
                                (PROD_W'(bs_r[j-1].steps) << (CHAN_W - j));
          bs_nxt[j].ch[c].q[CHAN_W-j] = 1'b1;
        end
      end
    end
  end

  // A one-pixel segment keeps the start colour.
  always_comb begin
    last = bs_r[CHAN_W];
    for (int c = 0; c < NUM_CHAN; c++) begin
      if (last.steps == '0)      v[c] = last.ch[c].c1;
      else if (last.ch[c].neg)   v[c] = last.ch[c].c1 - last.ch[c].q;
      else                       v[c] = last.ch[c].c1 + last.ch[c].q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bvld_r      <= '0;
      m_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (back_adv) begin
      bvld_r      <= {bvld_r[CHAN_W-1:0], pop_valid};
      m_vld_r     <= bvld_r[CHAN_W];
      out_valid_r <= m_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (back_adv) begin
      for (int j = 0; j <= CHAN_W; j++) bs_r[j] <= bs_nxt[j];
      m_pix_r <= last.pix;
      o_pix_r <= m_pix_r;
      for (int c = 0; c < NUM_CHAN; c++) begin
        m_prod_r[c] <= SW'(v[c]) * SW'(brightness);
        o_chan_r[c] <= div255(m_prod_r[c]);
      end
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.pixel_out_index = o_pix_r;
  assign out_ch.out_g           = o_chan_r[0];
  assign out_ch.out_r           = o_chan_r[1];
  assign out_ch.out_b           = o_chan_r[2];

endmodule

[rtl/multi_stop_rgb_gradient.sv]
// Top level of the multi-stop RGB gradient block.
//
//  Channel   Direction  Transfer moves
//  cfg_ch    in         register index and value (brightness, num_pixels, num_stops)
//  in_ch     in         one item: a colour stop load or a pixel render request
//  out_ch    out        one rendered pixel: its index and scaled G, R, B
//
// The block takes one input transfer per cycle while in_ch.ready is high. A render
// passes through the front, which finds the segment with an eight-stage pipelined
// divider and then reads both stops from the stop table, through the queue, and
// through the back, which divides the colour step in eight more pipelined stages and
// then scales by brightness. Loads and off-strip renders give no result. Reset, and
// every configuration write, start a sequencer that divides the strip into segments;
// in_ch.ready stays low until it is done. A stall on out_ch halts the back, the queue
// then fills, and only then does in_ch.ready fall.
module multi_stop_rgb_gradient import msrg_pkg::*; #(
  parameter int PIXELS_MAX = 256,
  parameter int STOPS_MAX  = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  msrg_cfg_if.sink   cfg_ch,
  msrg_in_if.sink    in_ch,
  msrg_out_if.source out_ch
);

  localparam int AW = $clog2(STOPS_MAX);

  logic [BRI_W-1:0] brightness;
  seg_info_t        seg;
  logic [AW-1:0]    last_k;
  logic             push_valid, push_ready;
  job_t             push_data;
  logic             pop_valid, pop_ready;
  job_t             pop_data;

  // Configuration registers and segment geometry.
  msrg_cfg #(
    .PIXELS_MAX (PIXELS_MAX),
    .STOPS_MAX  (STOPS_MAX)
  ) u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_ch     (cfg_ch),
    .brightness (brightness),
    .seg        (seg),
    .last_k     (last_k)
  );

  // Front: takes items, applies loads, classifies renders and fetches their stops.
  msrg_front #(
    .STOPS_MAX (STOPS_MAX)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .seg        (seg),
    .last_k     (last_k),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready)
  );

  // The queue lets the front keep accepting while the result side is stalled.
  msrg_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data),
    .pop_ready  (pop_ready)
  );

  // Back: interpolation, brightness scale and the output register.
  msrg_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data),
    .pop_ready  (pop_ready),
    .brightness (brightness),
    .out_ch     (out_ch)
  );

  // No item may enter while the segment geometry is being recomputed.
  assert property (@(posedge clk) disable iff (!rst_n) seg.busy |-> !in_ch.ready)
    else $error("input taken while segment geometry is busy");

  // Every configuration write restarts the geometry sequencer.
  assert property (@(posedge clk) disable iff (!rst_n)
                   (cfg_ch.valid && cfg_ch.ready) |=> seg.busy)
    else $error("configuration write did not restart the sequencer");

  // A queued render is never lost while the back end is stalled.
  assert property (@(posedge clk) disable iff (!rst_n)
                   (pop_valid && !pop_ready) |=> pop_valid)
    else $error("queued render vanished during a back-end stall");

  // The front holds a classified render while the queue is full.
  assert property (@(posedge clk) disable iff (!rst_n)
                   (push_valid && !push_ready) |=> push_valid)
    else $error("classified render dropped at a full queue");

endmodule

[sim/msrg_pixel_checker.sv]
// Checker that predicts and verifies every pixel the gradient block renders.
`timescale 1ns / 100ps
module msrg_pixel_checker import msrg_pkg::*; #(
  parameter int PIXELS_MAX = 256,
  parameter int STOPS_MAX  = 16
) (
  input  logic clk,
  input  logic rst_n,
  msrg_cfg_if  cfg_ch,
  msrg_in_if   in_ch,
  msrg_out_if  out_ch,
  output int   mismatches,
  output int   pending,
  output int   pixels_checked
);

  localparam int FULL_SCALE   = 255;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    grb_t             color;
  } lit_pixel_t;

  grb_t               stops [STOPS_MAX];
  logic [BRI_W-1:0]   bri;
  logic [NPIX_W-1:0]  npix_reg;
  logic [NSTOP_W-1:0] nstop_reg;
  lit_pixel_t         due_pixels [$];

  // Linear step between two stop channels, then the brightness scale.
  function automatic logic [CHAN_W-1:0] shade(input int c1, input int c2, input int pos,
                                              input int steps);
    int v;
    v = c1;
    if (steps > 0) v += ((c2 - c1) * pos) / steps;
    return CHAN_W'(((v & FULL_SCALE) * int'(bri)) / FULL_SCALE);
  endfunction

  // Returns 1 and the expected pixel when the pixel lies on the strip.
  function automatic bit render_pixel(input logic [PIX_W-1:0] pix, output lit_pixel_t res);
    int   strip, nst, segs, seg_size, seg, pos, count;
    grb_t a, b;
    strip = (int'(npix_reg) > PIXELS_MAX) ? PIXELS_MAX : int'(npix_reg);
    nst   = int'(nstop_reg);
    if (nst < 2) nst = 2;
    if (nst > STOPS_MAX) nst = STOPS_MAX;
    res = '0;
    if (int'(pix) >= strip) return 1'b0;
    segs     = nst - 1;
    seg_size = strip / segs;
    if (seg_size == 0) begin
      seg = segs - 1;
    end else begin
      seg = int'(pix) / seg_size;
      if (seg > segs - 1) seg = segs - 1;
    end
    pos   = int'(pix) - seg * seg_size;
    count = (seg == segs - 1) ? strip - seg_size * (segs - 1) : seg_size;
    a = stops[seg];
    b = stops[seg + 1];
    res.pix     = pix;
    res.color.g = shade(a.g, b.g, pos, count - 1);
    res.color.r = shade(a.r, b.r, pos, count - 1);
    res.color.b = shade(a.b, b.b, pos, count - 1);
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    lit_pixel_t want, got;
    if (!rst_n) begin
      bri       = BRIGHTNESS_RST;
      npix_reg  = NUM_PIXELS_RST;
      nstop_reg = NUM_STOPS_RST;
      foreach (stops[i]) stops[i] = '0;
      due_pixels.delete();
      mismatches     = 0;
      pixels_checked = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.pixel_out_index, out_ch.out_g, out_ch.out_r, out_ch.out_b};
        if (due_pixels.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("%t: unexpected pixel %0d g %0d r %0d b %0d", $time, got.pix,
                     got.color.g, got.color.r, got.color.b);
        end else begin
          want = due_pixels.pop_front();
          pixels_checked++;
          if (got.pix != want.pix || got.color.g != want.color.g ||
              got.color.r != want.color.r || got.color.b != want.color.b) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display("%t: pixel mismatch, expected %0d g %0d r %0d b %0d, got %0d g %0d r %0d b %0d",
                       $time, want.pix, want.color.g, want.color.r, want.color.b,
                       got.pix, got.color.g, got.color.r, got.color.b);
          end
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_BRIGHTNESS: bri       = cfg_ch.data[BRI_W-1:0];
          CFG_NUM_PIXELS: npix_reg  = cfg_ch.data[NPIX_W-1:0];
          CFG_NUM_STOPS:  nstop_reg = cfg_ch.data[NSTOP_W-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.op == OP_LOAD) begin
          if (int'(in_ch.stop_index) < STOPS_MAX)
            stops[in_ch.stop_index] = {in_ch.stop_g, in_ch.stop_r, in_ch.stop_b};
        end else if (render_pixel(in_ch.pixel_index, want)) begin
          due_pixels.push_back(want);
        end
      end
    end
    pending = due_pixels.size();
  end

endmodule

[sim/multi_stop_rgb_gradient_test.sv]
// Top of the gradient block's testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module multi_stop_rgb_gradient_test;
  import msrg_pkg::*;

  localparam int PIXELS_MAX   = 256;
  localparam int STOPS_MAX    = 16;
  localparam int HALF_PERIOD  = 5;
  localparam int IDLE_PCT     = 31;
  // Long enough for the front, the queue and the back to fill up completely.
  localparam int HOLD_CYCLES  = 200;
  // This covers a render's passage through the block with margin.
  localparam int DRAIN_CYCLES = 40;
  localparam int DRAIN_LIMIT  = 20000;
  localparam int LIMIT_NS     = 5_000_000;
  // The one register index that names no register.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  logic clk = 1'b0;
  logic rst_n;
  logic quiet;
  int   stall_asks;
  int   stalls_served;
  int   loads_sent;
  int   renders_sent;
  int   settings_run;
  int   strip;
  int   mismatches;
  int   pending;
  int   pixels_checked;

  msrg_cfg_if cfg_ch ();
  msrg_in_if  in_ch ();
  msrg_out_if out_ch ();

  multi_stop_rgb_gradient #(
    .PIXELS_MAX(PIXELS_MAX),
    .STOPS_MAX (STOPS_MAX)
  ) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg_ch(cfg_ch),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  msrg_pixel_checker #(
    .PIXELS_MAX(PIXELS_MAX),
    .STOPS_MAX (STOPS_MAX)
  ) pixel_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_ch        (cfg_ch),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .mismatches    (mismatches),
    .pending       (pending),
    .pixels_checked(pixels_checked)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // Hard limit on the run, far above the slowest legal run.
  initial begin
    #(LIMIT_NS);
    $display("multi_stop_rgb_gradient_test: done, errors");
    $finish;
  end

  // Receiver. It drops ready at random, except in quiet stretches, and serves
  // each hold-off request by keeping ready low for a counted number of cycles
  // while the sender keeps pushing, so the block has to back up its input.
  initial begin
    int held;
    stalls_served = 0;
    out_ch.ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_asks != stalls_served) begin
        out_ch.ready = 1'b0;
        for (held = 1; held < HOLD_CYCLES; held++) @(negedge clk);
        stalls_served++;
      end else begin
        out_ch.ready = quiet || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Offers one item on the input channel and returns right after the edge at
  // which it transfers. Random idle cycles go in front of the item.
  task automatic offer(input logic op, input logic [STOP_IDX_W-1:0] slot, input grb_t color,
                       input logic [PIX_W-1:0] pix);
    @(negedge clk);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid       = 1'b1;
    in_ch.op          = op;
    in_ch.stop_index  = slot;
    in_ch.stop_g      = color.g;
    in_ch.stop_r      = color.r;
    in_ch.stop_b      = color.b;
    in_ch.pixel_index = pix;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (op == OP_LOAD) loads_sent++;
    else renders_sent++;
  endtask

  // Stops the input and waits until every rendered pixel has come out. Loads
  // and off-strip renders leave nothing to wait for, so a full pipeline's worth
  // of cycles follows before the block counts as idle.
  task automatic settle();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  // Writes all three registers; now and then the unused index too, which the
  // block must ignore. Only called while the block is idle.
  task automatic apply_setting(input logic [CFG_DATA_W-1:0] bri, input logic [CFG_DATA_W-1:0] npix,
                               input logic [CFG_DATA_W-1:0] nst);
    write_reg(CFG_BRIGHTNESS, bri);
    write_reg(CFG_NUM_PIXELS, npix);
    write_reg(CFG_NUM_STOPS, nst);
    if ($urandom_range(3) == 0) write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
    @(negedge clk);
    cfg_ch.valid = 1'b0;
    strip = (int'(npix) > PIXELS_MAX) ? PIXELS_MAX : int'(npix);
    settings_run++;
  endtask

  // Random traffic: mostly renders of pixels on the strip, some stop reloads,
  // and some renders of any pixel index, which may fall off the strip. Fields
  // that an item does not use carry random bits.
  task automatic feed(input int n);
    int k, pick;
    for (k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      if (pick < 12)
        offer(OP_LOAD, STOP_IDX_W'($urandom), 24'($urandom), PIX_W'($urandom));
      else if (pick < 22 || strip == 0)
        offer(OP_RENDER, STOP_IDX_W'($urandom), 24'($urandom), PIX_W'($urandom));
      else
        offer(OP_RENDER, STOP_IDX_W'($urandom), 24'($urandom), PIX_W'($urandom_range(strip - 1)));
    end
  endtask

  task automatic run_phase(input logic [CFG_DATA_W-1:0] bri, input logic [CFG_DATA_W-1:0] npix,
                           input logic [CFG_DATA_W-1:0] nst, input int n);
    settle();
    apply_setting(bri, npix, nst);
    feed(n);
  endtask

  initial begin
    grb_t color;
    int   k;
    rst_n             = 1'b0;
    quiet             = 1'b0;
    stall_asks        = 0;
    loads_sent        = 0;
    renders_sent      = 0;
    settings_run      = 0;
    strip             = int'(NUM_PIXELS_RST);
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = CFG_BRIGHTNESS;
    cfg_ch.data       = '0;
    in_ch.valid       = 1'b0;
    in_ch.op          = OP_LOAD;
    in_ch.stop_index  = '0;
    in_ch.stop_g      = '0;
    in_ch.stop_r      = '0;
    in_ch.stop_b      = '0;
    in_ch.pixel_index = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Fill the whole stop table first, so no render ever reads a slot that
    // was never loaded. The first stops carry the channel extremes.
    for (k = 0; k < STOPS_MAX; k++) begin
      case (k)
        0:       color = '0;
        1:       color = '1;
        2:       color = {8'hFF, 8'h00, 8'hFF};
        3:       color = {8'h00, 8'hFF, 8'h00};
        default: color = 24'($urandom);
      endcase
      offer(OP_LOAD, STOP_IDX_W'(k), color, PIX_W'($urandom));
    end

    // Reset setting: a single pixel, which is a one-pixel segment, and two
    // renders past the end of the strip.
    offer(OP_RENDER, '0, '0, 8'd0);
    offer(OP_RENDER, '0, '0, 8'd1);
    offer(OP_RENDER, '0, '0, 8'd255);

    // Full strip, full brightness, all stops: both ends and a segment boundary.
    settle();
    apply_setting(9'd255, 9'd256, 9'd16);
    offer(OP_RENDER, '0, '0, 8'd0);
    offer(OP_RENDER, '0, '0, 8'd17);
    offer(OP_RENDER, '0, '0, 8'd254);
    offer(OP_RENDER, '0, '0, 8'd255);

    // Same setting under random traffic. Partway in, the receiver holds off
    // for a long stretch; later the sender pauses until every pixel is out.
    feed(60);
    stall_asks++;
    feed(120);
    settle();
    feed(40);

    run_phase(9'd0,    9'd256, 9'd2,  80);   // zero brightness, one segment
    run_phase(9'd100,  9'd1,   9'd16, 30);   // one pixel, many more segments
    run_phase(9'd200,  9'd15,  9'd16, 60);   // one-pixel segments everywhere
    run_phase(9'd77,   9'd10,  9'd16, 60);   // fewer pixels than segments
    run_phase(9'h1FF,  9'd511, 9'd31, 120);  // oversized strip and stop count
    run_phase(9'd128,  9'd0,   9'd1,  20);   // empty strip, too few stops
    run_phase(9'd60,   9'd300, 9'd0,  100);  // oversized strip, zero stops
    run_phase(9'd255,  9'd2,   9'd2,  40);   // two pixels, two stops

    // A stretch with no idling on either side.
    settle();
    apply_setting(9'd180, 9'd256, 9'd9);
    quiet = 1'b1;
    feed(100);
    quiet = 1'b0;

    // Random settings; the upper data bits are junk the block must drop.
    repeat (5) begin
      run_phase(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom_range(1, 256)),
                {4'($urandom), 5'($urandom_range(2, 16))}, 100);
    end

    @(negedge clk);
    in_ch.valid = 1'b0;
    for (k = 0; k < DRAIN_LIMIT && pending != 0; k++) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (pending != 0) $display("%0d rendered pixels never came out", pending);
    $display("Covered %0d register settings with %0d stop loads and %0d pixel renders.",
             settings_run, loads_sent, renders_sent);
    $display("Compared %0d pixels, found %0d mismatches.", pixels_checked, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("multi_stop_rgb_gradient_test: done, clean");
    end else begin
      $display("multi_stop_rgb_gradient_test: done, errors");
    end
    $finish;
  end

endmodule
